/* hw/rtl/shared_edge_table_top_defines.svh */
// Assertion macros shared by the checker of the shared edge table.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SHARED_EDGE_TABLE_TOP_DEFINES_SVH
`define SHARED_EDGE_TABLE_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SED_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("shared edge table: check failed");

// Check a consequence in the cycle after its cause.
`define SED_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("shared edge table: check failed");

`endif

/* hw/rtl/sed_pkg.sv */
// Types and codes of the shared edge table.
// No dependencies; used by every module of the block but sed_ram.
`default_nettype none

package sed_pkg;

  localparam int SLOT_W = 10;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [2:0] ST_NEW    = 3'd0;
  localparam logic [2:0] ST_SHARED = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_OVER   = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_HIT    = 3'd5;
  localparam logic [2:0] ST_MISS   = 3'd6;
  localparam logic [2:0] ST_BADIDX = 3'd7;

  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       from_point;
    logic [15:0]       to_point;
    logic [7:0]        region_id;
    logic [SLOT_W-1:0] entry_index;
  } sed_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       edge_from;
    logic [15:0]       edge_to;
    logic [7:0]        owner_region;
    logic [7:0]        partner_region;
    logic              is_shared;
    logic [SLOT_W-1:0] entry_count;
  } sed_out_t;

  // One stored table entry.
  typedef struct packed {
    logic [15:0] ep_from;
    logic [15:0] ep_to;
    logic [7:0]  first_region;
    logic [7:0]  second_region;
    logic        shared;
  } sed_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       scan_start;
    logic       scan_step;
    logic       rd_idx;
    logic       take_entry;
    logic       make_shared;
    logic       take_new;
    logic       take_empty;
    logic       empty_idx;
    logic [2:0] status;
    logic       out_load;
  } sed_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       pend_valid;
    logic       match;
    logic       same_dir;
    logic       shared;
    logic       scan_end;
    logic       full;
    logic       idx_ok;
  } sed_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/sed_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sed_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/sed_ctrl.sv */
// Controller of the shared edge table: sequences capture, scan or indexed read, update and output.
// Depends on sed_pkg.
`default_nettype none

module sed_ctrl import sed_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire sed_sts_t sts_i,
  output sed_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_RDWAIT   = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.mode)
          MODE_INSERT, MODE_LOOKUP: begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
          MODE_READ: begin
            if (sts_i.idx_ok) begin
              cmd_o.rd_idx = 1'b1;
              state_d      = S_RDWAIT;
            end else begin
              cmd_o.take_empty = 1'b1;
              cmd_o.empty_idx  = 1'b1;
              cmd_o.status     = ST_BADIDX;
              state_d          = S_FINISH;
            end
          end
          default: begin
            cmd_o.take_empty = 1'b1;
            cmd_o.status     = ST_BADIDX;
            state_d          = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts_i.pend_valid && sts_i.match) begin
          // First matching entry decides the outcome
          cmd_o.take_entry = 1'b1;
          state_d          = S_FINISH;
          if (sts_i.mode != MODE_INSERT) begin
            cmd_o.status = ST_HIT;
          end else if (sts_i.same_dir) begin
            cmd_o.status = ST_DUP;
          end else if (sts_i.shared) begin
            cmd_o.status = ST_OVER;
          end else begin
            cmd_o.make_shared = 1'b1;
            cmd_o.status      = ST_SHARED;
          end
        end else if (!sts_i.pend_valid && sts_i.scan_end) begin
          state_d = S_FINISH;
          if (sts_i.mode != MODE_INSERT) begin
            cmd_o.take_empty = 1'b1;
            cmd_o.status     = ST_MISS;
          end else if (sts_i.full) begin
            cmd_o.take_empty = 1'b1;
            cmd_o.status     = ST_FULL;
          end else begin
            cmd_o.take_new = 1'b1;
            cmd_o.status   = ST_NEW;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd_o.take_entry = 1'b1;
        cmd_o.status     = ST_HIT;
        state_d          = S_FINISH;
      end
      S_FINISH: begin
        // Hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/sed_datapath.sv */
// Datapath of the shared edge table: item register, entry RAM, scan pointer,
// fill count, compare logic and output register. Depends on sed_pkg, sed_ram.
`default_nettype none

module sed_datapath import sed_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sed_in_t  in_data_i,
  input  wire sed_cmd_t cmd_i,
  output sed_sts_t      sts_o,
  output sed_out_t      out_data_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = (AW > SLOT_W) ? AW : SLOT_W;

  sed_in_t    item_q;
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] scan_q, scan_d;
  logic          pend_valid_q, pend_valid_d;
  logic [AW-1:0] pend_idx_q;
  sed_entry_t    ent_q;
  logic [IW-1:0] slot_q;
  logic [2:0]    status_q;
  sed_out_t      out_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  sed_entry_t    ram_wdata, ram_rdata;
  sed_entry_t    shared_entry, new_entry;
  logic [IW-1:0] idx_w, fill_w;
  logic          same_dir, rev_dir, take_any;

  assign idx_w  = IW'(item_q.entry_index);
  assign fill_w = IW'(fill_q);

  always_comb begin
    shared_entry               = ram_rdata;
    shared_entry.shared        = 1'b1;
    shared_entry.second_region = item_q.region_id;
    new_entry.ep_from          = item_q.from_point;
    new_entry.ep_to            = item_q.to_point;
    new_entry.first_region     = item_q.region_id;
    new_entry.second_region    = '0;
    new_entry.shared           = 1'b0;
  end

  assign ram_raddr = cmd_i.rd_idx ? idx_w[AW-1:0] : scan_q;
  assign ram_we    = (cmd_i.take_entry & cmd_i.make_shared) | cmd_i.take_new;
  assign ram_waddr = cmd_i.take_new ? fill_q : pend_idx_q;
  assign ram_wdata = cmd_i.take_new ? new_entry : shared_entry;

  sed_ram #(
    .WIDTH ($bits(sed_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign same_dir = (ram_rdata.ep_from == item_q.from_point) &&
                    (ram_rdata.ep_to == item_q.to_point);
  assign rev_dir  = (ram_rdata.ep_from == item_q.to_point) &&
                    (ram_rdata.ep_to == item_q.from_point);

  always_comb begin
    sts_o.mode       = item_q.mode;
    sts_o.pend_valid = pend_valid_q;
    sts_o.match      = same_dir | rev_dir;
    sts_o.same_dir   = same_dir;
    sts_o.shared     = ram_rdata.shared;
    sts_o.scan_end   = (scan_q >= fill_q);
    sts_o.full       = (fill_q == AW'(TABLE_DEPTH - 1));
    sts_o.idx_ok     = (idx_w < fill_w);
  end

  // Scan pointer, outstanding read flag and fill count
  always_comb begin
    scan_d       = scan_q;
    pend_valid_d = pend_valid_q;
    fill_d       = fill_q;
    if (cmd_i.scan_start) begin
      scan_d       = '0;
      pend_valid_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      pend_valid_d = (scan_q < fill_q);
      if (scan_q < fill_q) begin
        scan_d = scan_q + AW'(1);
      end
    end
    if (cmd_i.take_new) begin
      fill_d = fill_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      scan_q       <= scan_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  assign take_any = cmd_i.take_entry | cmd_i.take_new | cmd_i.take_empty;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan_step && (scan_q < fill_q)) begin
      pend_idx_q <= scan_q;
    end else if (cmd_i.rd_idx) begin
      pend_idx_q <= idx_w[AW-1:0];
    end
    if (cmd_i.take_entry) begin
      ent_q  <= cmd_i.make_shared ? shared_entry : ram_rdata;
      slot_q <= IW'(pend_idx_q);
    end else if (cmd_i.take_new) begin
      ent_q  <= new_entry;
      slot_q <= fill_w;
    end else if (cmd_i.take_empty) begin
      ent_q  <= '0;
      slot_q <= cmd_i.empty_idx ? idx_w : '0;
    end
    if (take_any) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_q.status         <= status_q;
      out_q.slot           <= slot_q[SLOT_W-1:0];
      out_q.edge_from      <= ent_q.ep_from;
      out_q.edge_to        <= ent_q.ep_to;
      out_q.owner_region   <= ent_q.first_region;
      out_q.partner_region <= ent_q.shared ? ent_q.second_region : '0;
      out_q.is_shared      <= ent_q.shared;
      out_q.entry_count    <= fill_w[SLOT_W-1:0];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* hw/rtl/shared_edge_table_top.sv */
// Top level of the shared edge table: controller plus datapath.
// Depends on sed_pkg, sed_ctrl, sed_datapath (and sed_ram below it).
//
//   channel  direction  handshake                  word
//   input    in         in_valid_i / in_stall_o    sed_in_t  in_data_i
//   result   out        out_valid_o / out_stall_i  sed_out_t out_data_o
//
// Scan: an insert or lookup reads the stored entries in order from slot 0 up to
//   the fill count and stops at the first match; the entry RAM has one read
//   port, so the scan reads one stored entry per cycle. A read fetches the entry
//   at its index without a scan; a bad index or unused mode reads no entry.
// Reset: clears the fill count and the control state; the entry RAM is not
//   cleared, as only entries below the fill count are ever read.
// Stalls: the next word is accepted while a result waits in the output
//   register; the block then holds its finished result until that one is taken.
`default_nettype none

module shared_edge_table_top import sed_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire sed_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output sed_out_t     out_data_o
);

  // Commands down to the datapath, status back up
  sed_cmd_t cmd;
  sed_sts_t sts;

  sed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Entry RAM, scan pointer, fill count and the output register live here
  sed_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/sed_checker.sv */
// Port-level checks of the shared edge table, bound to the top level.
// Depends on sed_pkg and shared_edge_table_top_defines.svh.
`default_nettype none

`include "shared_edge_table_top_defines.svh"

module sed_checker import sed_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire sed_out_t out_data_o
);

  logic unshared_status;

  assign unshared_status = (out_data_o.status == ST_FULL) ||
                           (out_data_o.status == ST_MISS) ||
                           (out_data_o.status == ST_NEW);

  // One word at a time: busy right after an accept
  `SED_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Hold a stalled result
  `SED_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // A shared outcome shows a shared entry; a new, full or miss outcome shows none and no partner region
  `SED_ASSERT_NOW(a_shared_flag, out_valid_o && (out_data_o.status == ST_SHARED), out_data_o.is_shared)
  `SED_ASSERT_NOW(a_empty_fields, out_valid_o && unshared_status, !out_data_o.is_shared && (out_data_o.partner_region == 8'd0))

endmodule

bind shared_edge_table_top sed_checker u_sed_checker (.*);

`default_nettype wire
